[rtl/core/axis_cumulative_sum_assert.svh]
// ---------------------------------------------------------------------------
// axis_cumulative_sum assertion macros
// shorthand for the clocked checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef AXIS_CUMULATIVE_SUM_ASSERT_SVH
`define AXIS_CUMULATIVE_SUM_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define ACS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define ACS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/acs_pkg.sv]
// ---------------------------------------------------------------------------
// acs_pkg
// shared types, register indices and arithmetic for the cumulative sum block
// ---------------------------------------------------------------------------
package acs_pkg;

  localparam int COLS_MAX_DEF  = 256;
  localparam int ROWS_MAX_DEF  = 4096;
  localparam int SLABS_MAX_DEF = 65536;

  localparam int DATA_W   = 32;
  localparam int CFG_DW   = 17;  // widest register: slab_count
  localparam int CFG_IW   = 3;
  localparam int SLAB_IDX_W = 16;
  localparam int ROW_IDX_W  = 12;
  localparam int COL_IDX_W  = 8;

  typedef enum logic [CFG_IW-1:0] {
    REG_SLAB_COUNT = 3'd0,
    REG_ROW_COUNT  = 3'd1,
    REG_COL_COUNT  = 3'd2,
    REG_EXCL_MODE  = 3'd3,
    REG_REV_MODE   = 3'd4
  } acs_reg_t;

  // position of one word in the tensor, travels with it down the pipe
  typedef struct packed {
    logic                  first_row;
    logic [SLAB_IDX_W-1:0] slab_index;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [COL_IDX_W-1:0]  col_index;
    logic                  slab_done;
    logic                  all_done;
  } acs_pos_t;

  // signed add clipped to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

[rtl/core/acs_seq.sv]
// ---------------------------------------------------------------------------
// acs_seq
// configuration registers and the slab / row / column traversal counters
// ---------------------------------------------------------------------------
module acs_seq import acs_pkg::*; #(
  parameter int COLS_MAX  = COLS_MAX_DEF,
  parameter int ROWS_MAX  = ROWS_MAX_DEF,
  parameter int SLABS_MAX = SLABS_MAX_DEF,
  localparam int CIW = (COLS_MAX  > 1) ? $clog2(COLS_MAX)  : 1,
  localparam int RCW = (ROWS_MAX  > 1) ? $clog2(ROWS_MAX)  : 1,
  localparam int SCW = (SLABS_MAX > 1) ? $clog2(SLABS_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              step,
  output logic [CIW-1:0]    col_addr,
  output acs_pos_t          pos,
  output logic              excl_mode
);

  logic [SCW-1:0] slab_last_r, slab_r, slab_nxt;
  logic [RCW-1:0] row_last_r, row_r, row_nxt, row_dest;
  logic [CIW-1:0] col_last_r, col_r, col_nxt;
  logic           excl_r, rev_r;
  logic           is_last_col, is_last_row, is_last_slab;
  logic [31:0]    wv, wv_row, wv_col;
  logic [31:0]    slab_ext, row_ext, col_ext;

  // count register value to last index, 0 acts as 1 and large values clip
  assign wv     = 32'(cfg_wdata);
  // row_count is 13 bits and col_count 9 bits wide, upper write bits dropped
  assign wv_row = 32'(cfg_wdata[12:0]);
  assign wv_col = 32'(cfg_wdata[8:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_last_r <= '0;
      row_last_r  <= '0;
      col_last_r  <= '0;
      excl_r      <= 1'b0;
      rev_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLAB_COUNT: begin
          if (wv == 32'd0)                    slab_last_r <= '0;
          else if (wv > 32'(SLABS_MAX))       slab_last_r <= SCW'(SLABS_MAX - 1);
          else                                slab_last_r <= SCW'(wv - 32'd1);
        end
        REG_ROW_COUNT: begin
          if (wv_row == 32'd0)                row_last_r <= '0;
          else if (wv_row > 32'(ROWS_MAX))    row_last_r <= RCW'(ROWS_MAX - 1);
          else                                row_last_r <= RCW'(wv_row - 32'd1);
        end
        REG_COL_COUNT: begin
          if (wv_col == 32'd0)                col_last_r <= '0;
          else if (wv_col > 32'(COLS_MAX))    col_last_r <= CIW'(COLS_MAX - 1);
          else                                col_last_r <= CIW'(wv_col - 32'd1);
        end
        REG_EXCL_MODE: excl_r <= cfg_wdata[0];
        REG_REV_MODE:  rev_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign is_last_col  = (col_r == col_last_r);
  assign is_last_row  = (row_r == row_last_r);
  assign is_last_slab = (slab_r == slab_last_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slab_nxt = slab_r;
    if (step) begin
      if (!is_last_col) begin
        col_nxt = col_r + 1'b1;
      end else begin
        col_nxt = '0;
        if (!is_last_row) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt  = '0;
          slab_nxt = is_last_slab ? '0 : slab_r + 1'b1;
        end
      end
    end
  end

  // a valid register write restarts the traversal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_we && (cfg_idx <= REG_REV_MODE)) begin
      slab_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      slab_r <= slab_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign row_dest = rev_r ? (row_last_r - row_r) : row_r;
  assign slab_ext = 32'(slab_r);
  assign row_ext  = 32'(row_dest);
  assign col_ext  = 32'(col_r);

  assign col_addr       = col_r;
  assign excl_mode      = excl_r;
  assign pos.first_row  = (row_r == '0);
  assign pos.slab_index = slab_ext[SLAB_IDX_W-1:0];
  assign pos.row_index  = row_ext[ROW_IDX_W-1:0];
  assign pos.col_index  = col_ext[COL_IDX_W-1:0];
  assign pos.slab_done  = is_last_col && is_last_row;
  assign pos.all_done   = is_last_col && is_last_row && is_last_slab;

endmodule

[rtl/core/acs_accum.sv]
// ---------------------------------------------------------------------------
// acs_accum
// per-column sum memory with read-modify-write and write-to-read forwarding
// ---------------------------------------------------------------------------
module acs_accum import acs_pkg::*; #(
  parameter int COLS_MAX = COLS_MAX_DEF,
  localparam int CIW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     issue,
  input  logic [CIW-1:0]           issue_addr,
  input  logic signed [DATA_W-1:0] issue_x,
  input  acs_pos_t                 issue_pos,
  input  logic                     excl_mode,
  input  logic                     advance,
  output logic                     res_vld,
  output logic signed [DATA_W-1:0] res_sum,
  output acs_pos_t                 res_pos
);

  logic signed [DATA_W-1:0] mem [COLS_MAX];
  logic signed [DATA_W-1:0] rdata_r;
  logic                     a_vld_r;
  logic [CIW-1:0]           a_addr_r;
  logic signed [DATA_W-1:0] a_x_r;
  acs_pos_t                 a_pos_r;
  logic                     fwd_vld_r;
  logic [CIW-1:0]           fwd_addr_r;
  logic signed [DATA_W-1:0] fwd_data_r;
  logic signed [DATA_W-1:0] old_sum, new_sum;
  logic                     wr_en;

  assign wr_en = a_vld_r && advance;

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[issue_addr];
    end
    if (wr_en) begin
      mem[a_addr_r] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (issue)        a_vld_r <= 1'b1;
      else if (advance) a_vld_r <= 1'b0;
      if (wr_en)        fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_addr_r <= issue_addr;
      a_x_r    <= issue_x;
      a_pos_r  <= issue_pos;
    end
    if (wr_en) begin
      fwd_addr_r <= a_addr_r;
      fwd_data_r <= new_sum;
    end
  end

  // last write may land on the same edge as this word's read
  assign old_sum = (fwd_vld_r && (fwd_addr_r == a_addr_r)) ? fwd_data_r : rdata_r;
  assign new_sum = a_pos_r.first_row ? a_x_r : sat_add(old_sum, a_x_r);

  assign res_vld = a_vld_r;
  assign res_pos = a_pos_r;
  always_comb begin
    if (!excl_mode)             res_sum = new_sum;
    else if (a_pos_r.first_row) res_sum = '0;
    else                        res_sum = old_sum;
  end

endmodule

[rtl/core/axis_cumulative_sum.sv]
// ---------------------------------------------------------------------------
// axis_cumulative_sum
// running sum down the rows of a slabs x rows x columns tensor, per column
// ---------------------------------------------------------------------------
// Streams one Q16.16 word per cycle while the output is not held, slab by
// slab, row by row, columns ascending inside a row (destination rows falling
// per slab in reverse mode), and returns one saturated running sum per word
// (the sum before it in exclusive mode) with its destination indices and
// end-of-slab / end-of-tensor flags. Sustained rate is one word per clock
// unless the output is held; an accepted word passes the compute stage and
// output registers. The rate is set by the read-modify-write on the column
// sum memory, which has one read and one write port: read on accept, add and
// write back as the word leaves the compute stage, with the previous write
// forwarded on a same-column hit. No clearing pass is needed after reset:
// the first row of every slab overwrites its column entry.
// Register writes (any valid index) restart the traversal at the first
// element; they must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module axis_cumulative_sum import acs_pkg::*; #(
  parameter int COLS_MAX  = COLS_MAX_DEF,
  parameter int ROWS_MAX  = ROWS_MAX_DEF,
  parameter int SLABS_MAX = SLABS_MAX_DEF,
  localparam int CIW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IW-1:0]            cfg_idx,
  input  logic [CFG_DW-1:0]            cfg_wdata,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_W-1:0]     in_sample_value,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_W-1:0]     out_sum_value,
  output logic [SLAB_IDX_W-1:0]        out_slab_index,
  output logic [ROW_IDX_W-1:0]         out_row_index,
  output logic [COL_IDX_W-1:0]         out_col_index,
  output logic                         out_slab_done,
  output logic                         out_all_done
);

  logic                     in_take;
  logic                     a_vld;
  logic                     a_go;
  logic [CIW-1:0]           col_addr;
  acs_pos_t                 seq_pos;
  acs_pos_t                 a_pos;
  logic                     excl_mode;
  logic signed [DATA_W-1:0] a_sum;

  // output register frees when empty or when the consumer takes it
  assign a_go     = !out_valid || !out_stall;
  // the compute stage accepts a new word as long as it can move on
  assign in_stall = a_vld && !a_go;
  assign in_take  = in_valid && !in_stall;

  // traversal counters and configuration
  acs_seq #(
    .COLS_MAX  (COLS_MAX),
    .ROWS_MAX  (ROWS_MAX),
    .SLABS_MAX (SLABS_MAX)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (in_take),
    .col_addr  (col_addr),
    .pos       (seq_pos),
    .excl_mode (excl_mode)
  );

  // column sum memory, read on accept and written back from the compute stage
  acs_accum #(
    .COLS_MAX (COLS_MAX)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (in_take),
    .issue_addr (col_addr),
    .issue_x    (in_sample_value),
    .issue_pos  (seq_pos),
    .excl_mode  (excl_mode),
    .advance    (a_go),
    .res_vld    (a_vld),
    .res_sum    (a_sum),
    .res_pos    (a_pos)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (a_go) begin
      out_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_vld) begin
      out_sum_value  <= a_sum;
      out_slab_index <= a_pos.slab_index;
      out_row_index  <= a_pos.row_index;
      out_col_index  <= a_pos.col_index;
      out_slab_done  <= a_pos.slab_done;
      out_all_done   <= a_pos.all_done;
    end
  end

  // checks
  `include "axis_cumulative_sum_assert.svh"

  // the input only backs up when both stages are full and the output is held
  `ACS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall && a_vld, "bad input stall")
  // an accepted word always lands in the compute stage
  `ACS_ASSERT_NEXT(a_take_lands, in_take, a_vld, "accepted word lost")
  // end of tensor is also end of a slab
  `ACS_ASSERT_NOW(a_done_nest, out_valid && out_all_done, out_slab_done, "all_done without slab_done")

endmodule

[dv/axis_cumulative_sum_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_cumulative_sum_checker
// predicts every result word of the cumulative sum block and compares it
// ---------------------------------------------------------------------------
// Mirrors register writes and input words into its own copy of the column
// totals and traversal counters, queues the predicted result words and
// checks each accepted output word field by field, oldest first.
// ---------------------------------------------------------------------------
module axis_cumulative_sum_checker import acs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_idx,
  input  logic [CFG_DW-1:0]        cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_sum_value,
  input  logic [SLAB_IDX_W-1:0]    out_slab_index,
  input  logic [ROW_IDX_W-1:0]     out_row_index,
  input  logic [COL_IDX_W-1:0]     out_col_index,
  input  logic                     out_slab_done,
  input  logic                     out_all_done,
  output int                       pending_words,
  output int                       error_count
);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] sum_value;
    logic [SLAB_IDX_W-1:0]    slab_index;
    logic [ROW_IDX_W-1:0]     row_index;
    logic [COL_IDX_W-1:0]     col_index;
    logic                     slab_done;
    logic                     all_done;
  } sum_word_t;

  // register copies
  int slab_reg;
  int row_reg;
  int col_reg;
  bit excl_reg;
  bit rev_reg;

  // traversal position and per-column totals
  int at_slab;
  int at_row;
  int at_col;
  logic signed [DATA_W-1:0] column_totals [COLS_MAX_DEF];

  sum_word_t expected_sums [$];

  function automatic int clamp_count(input int v, input int maxv);
    if (v == 0) begin
      return 1;
    end
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    longint total;
    total = longint'(a) + longint'(b);
    if (total > longint'(Q_MAX)) begin
      return Q_MAX;
    end
    if (total < longint'(Q_MIN)) begin
      return Q_MIN;
    end
    return total[DATA_W-1:0];
  endfunction

  function automatic sum_word_t predict_sum(input logic signed [DATA_W-1:0] x);
    int slabs;
    int rows;
    int cols;
    sum_word_t w;
    logic signed [DATA_W-1:0] next_total;
    slabs = clamp_count(slab_reg, SLABS_MAX_DEF);
    rows  = clamp_count(row_reg, ROWS_MAX_DEF);
    cols  = clamp_count(col_reg, COLS_MAX_DEF);
    if (at_slab >= slabs || at_row >= rows || at_col >= cols) begin
      at_slab = 0;
      at_row  = 0;
      at_col  = 0;
    end
    // first row visited overwrites the column total
    if (at_row == 0) begin
      w.sum_value = excl_reg ? '0 : x;
      column_totals[at_col] = x;
    end else begin
      next_total = clip_add(column_totals[at_col], x);
      w.sum_value = excl_reg ? column_totals[at_col] : next_total;
      column_totals[at_col] = next_total;
    end
    w.slab_index = SLAB_IDX_W'(at_slab);
    w.row_index  = ROW_IDX_W'(rev_reg ? rows - 1 - at_row : at_row);
    w.col_index  = COL_IDX_W'(at_col);
    w.slab_done  = (at_col + 1 == cols) && (at_row + 1 == rows);
    w.all_done   = w.slab_done && (at_slab + 1 == slabs);
    if (at_col + 1 != cols) begin
      at_col++;
    end else begin
      at_col = 0;
      if (at_row + 1 != rows) begin
        at_row++;
      end else begin
        at_row  = 0;
        at_slab = (at_slab + 1 == slabs) ? 0 : at_slab + 1;
      end
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      error_count++;
    end
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    sum_word_t want;
    if (!rst_n) begin
      slab_reg = 1;
      row_reg  = 1;
      col_reg  = 1;
      excl_reg = 1'b0;
      rev_reg  = 1'b0;
      at_slab  = 0;
      at_row   = 0;
      at_col   = 0;
      expected_sums.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SLAB_COUNT: slab_reg = int'(cfg_wdata);
          REG_ROW_COUNT:  row_reg  = int'(cfg_wdata[12:0]);
          REG_COL_COUNT:  col_reg  = int'(cfg_wdata[8:0]);
          REG_EXCL_MODE:  excl_reg = cfg_wdata[0];
          REG_REV_MODE:   rev_reg  = cfg_wdata[0];
          default: ;
        endcase
        // any known register restarts the walk, stray indexes do nothing
        if (cfg_idx <= REG_REV_MODE) begin
          at_slab = 0;
          at_row  = 0;
          at_col  = 0;
        end
      end
      if (in_valid && !in_stall) begin
        expected_sums.push_back(predict_sum(in_sample_value));
      end
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $error("result word with no prediction waiting");
          error_count++;
        end else begin
          want = expected_sums.pop_front();
          check_field("sum_value", want.sum_value, out_sum_value);
          check_field("slab_index", want.slab_index, out_slab_index);
          check_field("row_index", want.row_index, out_row_index);
          check_field("col_index", want.col_index, out_col_index);
          check_field("slab_done", want.slab_done, out_slab_done);
          check_field("all_done", want.all_done, out_all_done);
        end
      end
    end
    pending_words <= expected_sums.size();
  end

endmodule

[dv/axis_cumulative_sum_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_cumulative_sum_tb
// stimulus and verdict for the cumulative sum block
// ---------------------------------------------------------------------------
// A directed opening covers the value extremes, saturation both ways, both
// mode bits, out-of-range counts and a stray register index; then random
// tensor shapes are streamed with random content, mostly as whole tensors.
// Both channels idle at random; the checker beside the block does the
// prediction and comparison.
// ---------------------------------------------------------------------------
module axis_cumulative_sum_tb;
  import acs_pkg::*;

  localparam int WORD_TARGET  = 1950;
  localparam int IDLE_PERCENT = 37;
  localparam int DRAIN_CYCLES = 6;     // a little margin after the queue drains
  localparam int HANG_LIMIT   = 2000;  // cycles with no handshake at all

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  // every input known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IW-1:0]        cfg_idx = REG_SLAB_COUNT;
  logic [CFG_DW-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_sample_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_sum_value;
  logic [SLAB_IDX_W-1:0]    out_slab_index;
  logic [ROW_IDX_W-1:0]     out_row_index;
  logic [COL_IDX_W-1:0]     out_col_index;
  logic                     out_slab_done;
  logic                     out_all_done;

  int pending_words;
  int error_count;
  int words_sent = 0;
  int stuck_cycles = 0;
  bit quiet = 1'b0;  // no idling on either side while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  axis_cumulative_sum DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_value   (out_sum_value),
    .out_slab_index  (out_slab_index),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_slab_done   (out_slab_done),
    .out_all_done    (out_all_done)
  );

  axis_cumulative_sum_checker sum_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_value   (out_sum_value),
    .out_slab_index  (out_slab_index),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_slab_done   (out_slab_done),
    .out_all_done    (out_all_done),
    .pending_words   (pending_words),
    .error_count     (error_count)
  );

  // receiver back-pressure, one fresh draw per cycle
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // hang guard: any handshake or register write resets the count
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= HANG_LIMIT) begin
      $display("axis_cumulative_sum_tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one register write per clock, write enable left high for the next one
  task automatic reg_write(input logic [CFG_IW-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(posedge clk);
  endtask

  // whole register set, optionally followed by a write to an unused index
  task automatic set_shape(input int slabs, input int rows, input int cols,
                           input bit excl, input bit rev, input bit stray);
    reg_write(REG_SLAB_COUNT, slabs);
    reg_write(REG_ROW_COUNT, rows);
    reg_write(REG_COL_COUNT, cols);
    reg_write(REG_EXCL_MODE, excl);
    reg_write(REG_REV_MODE, rev);
    if (stray) begin
      reg_write(CFG_IW'($urandom_range((1 << CFG_IW) - 1, REG_REV_MODE + 1)),
                $urandom_range(0, (1 << CFG_DW) - 1));
    end
    cfg_we <= 1'b0;
  endtask

  // present one word, idling beforehand at random, and wait for acceptance
  task automatic send_word(input logic signed [DATA_W-1:0] value);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // stop sending and let every predicted word drain out of the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // extremes, large magnitudes for saturation, and small fractions
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3, 4: return $urandom;
      5:       return $urandom | 32'h6000_0000;
      6:       return $urandom & 32'h9FFF_FFFF | 32'h8000_0000;
      default: return $urandom_range(0, 32'h3_FFFF) - 32'sh1_FFFF;
    endcase
  endfunction

  initial begin
    int slabs_w;
    int rows_w;
    int cols_w;
    int span;
    int phase_words;
    bit big_shape;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape is a single element: every word is its own tensor
    send_word(Q_MAX);
    send_word(Q_MIN);
    send_word('0);
    send_word(-1);
    send_word(Q_ONE);
    wait_idle();

    // saturation upwards in column 0, downwards in column 1
    set_shape(1, 3, 2, 1'b0, 1'b0, 1'b0);
    send_word(Q_MAX);
    send_word(Q_MIN);
    send_word(Q_MAX);
    send_word(-1);
    send_word(Q_MIN);
    send_word(Q_MIN);
    wait_idle();

    // exclusive and reverse together over two slabs
    set_shape(2, 2, 1, 1'b1, 1'b1, 1'b0);
    send_word(5 * Q_ONE);
    send_word(7);
    send_word(-3);
    send_word(32'sh4000_0000);
    wait_idle();

    // zero counts act as one, unused index must leave everything alone
    set_shape(0, 0, 0, 1'b0, 1'b1, 1'b1);
    send_word(32'sh1234_5678);
    send_word(32'shEDCB_A988);
    wait_idle();

    // counts beyond the maximum clip to it: row index starts at 4095
    set_shape((1 << CFG_DW) - 1, (1 << 13) - 1, (1 << 9) - 1, 1'b1, 1'b1, 1'b0);
    repeat (6) send_word(pick_sample());
    wait_idle();

    // random shapes, mostly whole tensors with random content
    while (words_sent < WORD_TARGET) begin
      wait_idle();
      big_shape = ($urandom_range(0, 19) == 0);
      if (big_shape) begin
        slabs_w     = $urandom_range(1 << 16, (1 << CFG_DW) - 1);
        rows_w      = $urandom_range(1, (1 << 13) - 1);
        cols_w      = $urandom_range(1, (1 << 9) - 1);
        phase_words = $urandom_range(20, 60);
      end else begin
        slabs_w     = $urandom_range(0, 3);
        rows_w      = $urandom_range(0, 6);
        cols_w      = $urandom_range(0, 8);
        span        = (slabs_w == 0 ? 1 : slabs_w) * (rows_w == 0 ? 1 : rows_w)
                    * (cols_w == 0 ? 1 : cols_w);
        phase_words = span * $urandom_range(1, 2);
        // broken tensor now and then, cut short by the next register write
        if ($urandom_range(0, 4) == 0) begin
          phase_words = $urandom_range(1, span);
        end
      end
      set_shape(slabs_w, rows_w, cols_w, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 7) == 0);
      // a long stretch with no idling on either side
      quiet = (words_sent >= 700 && words_sent < 1000);
      repeat (phase_words) begin
        // occasional mid-tensor pause until the block has drained
        if ($urandom_range(0, 199) == 0) begin
          wait_idle();
        end
        send_word(pick_sample());
      end
    end
    quiet = 1'b0;
    wait_idle();

    if (error_count == 0 && pending_words == 0) begin
      $display("axis_cumulative_sum_tb: clean");
    end else begin
      $display("axis_cumulative_sum_tb: errors");
    end
    $finish;
  end

endmodule
